// ----- hdl/dbcw_pkg.sv -----
// Shared types and fixed constants for the delay-based congestion window.
// No dependencies; imported by delay_based_congestion_window_top and tb_top.
`timescale 1ns / 1ps

package dbcw_pkg;

  // Time stamps and RTT are 64-bit values, processed 4 bits per cycle.
  localparam int TIME_W     = 64;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = TIME_W / DIGIT_W;

  // Configuration registers
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_WINDOW  = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  THRESHOLD_RESET     = 16'd80;

  // Event kinds carried in the mode field
  localparam logic MODE_SEND = 1'b0;
  localparam logic MODE_ACK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RTT,
    ST_ADJUST,
    ST_DIVIDE,
    ST_GROW,
    ST_FINISH
  } state_t;

  // Running comparison of RTT against threshold, least significant digit first
  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_GT,
    CMP_LT
  } cmp_t;

endpackage

// ----- hdl/delay_based_congestion_window_top.sv -----
// Delay-based AIMD congestion window: digit-serial RTT, serial divider, window update.
// Depends on dbcw_pkg (types, time-stamp width, digit width, register indexes).
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------------
//  s_*     | in        | s_tvalid / s_tready | s_tuser: mode, timeout flag
//          |           |                     | s_tdata: send_time_ms, ack_time_ms
//  m_*     | out       | m_tvalid / m_tready | m_tdata: window_whole, window_fixed, rtt_ms
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Steps: a send event passes through the adjust and finish states; an ack event first
//  runs the 4-bit serial subtractor that forms the 64-bit RTT and compares it with the
//  threshold; an ack that grows the window then runs the restoring divider, one quotient
//  bit per cycle, and the saturating add.
//  Reset: window loads 1.0, threshold loads 80; no clearing pass.
//  Stalls: the result waits in the output register while the next request is taken;
//  a second finished result holds in the last step until the first one leaves.
//  Configuration writes are always ready and are expected only while idle.

module delay_based_congestion_window_top #(
  parameter int FRACTION_BITS = 8,
  parameter int WHOLE_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input requests
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [1:0]                           s_tuser,   // [0] mode, [1] timeout flag
  input  logic [2*dbcw_pkg::TIME_W-1:0]        s_tdata,   // [63:0] send_time_ms,
                                                          // [127:64] ack_time_ms
  // Results
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((WHOLE_BITS + WHOLE_BITS + FRACTION_BITS + dbcw_pkg::TIME_W + 7) / 8) * 8 - 1:0]
                                               m_tdata,   // window_whole, window_fixed,
                                                          // rtt_ms, zero pad
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dbcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dbcw_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dbcw_pkg::*;

  localparam int WIN_W     = WHOLE_BITS + FRACTION_BITS;
  localparam int DIV_STEPS = FRACTION_BITS + 3;          // width of 4.0 in fixed point
  localparam int CNT_MAX   = (NUM_DIGITS > DIV_STEPS) ? NUM_DIGITS : DIV_STEPS;
  localparam int CNT_W     = $clog2(CNT_MAX);
  localparam int OUT_BITS  = WHOLE_BITS + WIN_W + TIME_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [WIN_W-1:0] WIN_ONE  = {{(WIN_W-1){1'b0}}, 1'b1};
  localparam logic [WIN_W-1:0] ONE_FX   = WIN_ONE << FRACTION_BITS;
  localparam logic [WIN_W-1:0] HALF_FX  = WIN_ONE << (FRACTION_BITS - 1);
  localparam logic [WIN_W-1:0] TWO_FX   = WIN_ONE << (FRACTION_BITS + 1);
  localparam logic [WIN_W-1:0] WIN_MAX  = {WIN_W{1'b1}};
  localparam logic [DIV_STEPS-1:0] FOUR_FX = {1'b1, {(DIV_STEPS-1){1'b0}}};
  localparam logic [32:0] WHOLE_MAX_EXT = (33'd1 << WHOLE_BITS) - 33'd1;
  localparam logic [CNT_W-1:0] RTT_LAST = CNT_W'(NUM_DIGITS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  state_t state, state_next;

  // Control
  logic [CNT_W-1:0]      cnt;
  logic                  borrow;
  cmp_t                  cmp;
  logic                  mode;
  logic                  timed_out;

  // Datapath
  logic [CFG_DATA_W-1:0] threshold;
  logic [WIN_W-1:0]      window;
  logic [TIME_W-1:0]     ack_sr;
  logic [TIME_W-1:0]     send_sr;
  logic [TIME_W-1:0]     thr_sr;
  logic [TIME_W-1:0]     rtt_sr;
  logic [WHOLE_BITS-1:0] rem;
  logic [DIV_STEPS-1:0]  quo;            // numerator bits shift out, quotient bits in

  // Output register
  logic [WIN_W-1:0]      out_window;
  logic [TIME_W-1:0]     out_rtt;

  logic                  s_fire;
  logic                  m_fire;
  logic                  out_load;

  // ---------------------------------------------------------------------------
  // Serial RTT digit: ack minus send with borrow, then compare against threshold
  // ---------------------------------------------------------------------------
  logic [DIGIT_W:0]      digit_diff;
  logic [DIGIT_W-1:0]    rtt_digit;
  logic [DIGIT_W-1:0]    thr_digit;
  cmp_t                  cmp_next;

  always_comb begin
    digit_diff = {1'b0, ack_sr[DIGIT_W-1:0]} - {1'b0, send_sr[DIGIT_W-1:0]}
                 - {{DIGIT_W{1'b0}}, borrow};
    rtt_digit  = digit_diff[DIGIT_W-1:0];
    thr_digit  = thr_sr[DIGIT_W-1:0];
    // A higher digit that differs overrides everything below it
    if (rtt_digit > thr_digit) begin
      cmp_next = CMP_GT;
    end else if (rtt_digit < thr_digit) begin
      cmp_next = CMP_LT;
    end else begin
      cmp_next = cmp;
    end
  end

  // ---------------------------------------------------------------------------
  // Ack adjustment: take 0.5 off on a late ack (floor at zero), clamp to 1.0
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0] win_dec;
  logic [WIN_W-1:0] win_mid;
  logic [WIN_W-1:0] win_clamp;

  always_comb begin
    win_dec   = (window >= HALF_FX) ? (window - HALF_FX) : '0;
    win_mid   = (cmp == CMP_GT) ? win_dec : window;
    win_clamp = (win_mid < ONE_FX) ? ONE_FX : win_mid;
  end

  // ---------------------------------------------------------------------------
  // Restoring divider step: 4.0 divided by the whole part of the window
  // ---------------------------------------------------------------------------
  logic [WHOLE_BITS-1:0] divisor;
  logic [WHOLE_BITS:0]   div_shifted;
  logic [WHOLE_BITS:0]   div_trial;
  logic                  div_ge;

  always_comb begin
    divisor     = window[WIN_W-1:FRACTION_BITS];
    div_shifted = {rem, quo[DIV_STEPS-1]};
    div_ge      = (div_shifted >= {1'b0, divisor});
    div_trial   = div_shifted - {1'b0, divisor};
  end

  // Saturating growth
  logic [WIN_W:0] grow_sum;
  assign grow_sum = {1'b0, window} + (WIN_W+1)'(quo);

  // Window load value from a configuration write: zero reads as one, saturate
  logic [32:0]           init_ext;
  logic [32:0]           init_sel;
  logic [WHOLE_BITS-1:0] init_whole;

  always_comb begin
    init_ext = {17'd0, cfg_data};
    if (cfg_data == '0) begin
      init_sel = 33'd1;
    end else if (init_ext > WHOLE_MAX_EXT) begin
      init_sel = WHOLE_MAX_EXT;
    end else begin
      init_sel = init_ext;
    end
    init_whole = init_sel[WHOLE_BITS-1:0];
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          state_next = (s_tuser[0] == MODE_ACK) ? ST_RTT : ST_ADJUST;
        end
      end
      ST_RTT: begin
        if (cnt == RTT_LAST) begin
          state_next = ST_ADJUST;
        end
      end
      ST_ADJUST: begin
        if (mode == MODE_ACK && cmp == CMP_LT) begin
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (cnt == DIV_LAST) begin
          state_next = ST_GROW;
        end
      end
      ST_GROW: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    s_tready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    s_fire    = s_tvalid && s_tready;
    m_fire    = m_tvalid && m_tready;
    // Load the result once the output register is free or drains this cycle
    out_load  = (state == ST_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      borrow    <= 1'b0;
      cmp       <= CMP_EQ;
      m_tvalid  <= 1'b0;
      threshold <= THRESHOLD_RESET;
      window    <= ONE_FX;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt    <= '0;
          borrow <= 1'b0;
          cmp    <= CMP_EQ;
        end
        ST_RTT: begin
          borrow <= digit_diff[DIGIT_W];
          cmp    <= cmp_next;
          cnt    <= (cnt == RTT_LAST) ? '0 : cnt + 1'b1;
        end
        ST_ADJUST: begin
          cnt <= '0;
          if (mode == MODE_SEND) begin
            // Timeout halves a window above 2.0, dropping the lowest fraction bit
            if (timed_out && window > TWO_FX) begin
              window <= window >> 1;
            end
          end else begin
            window <= win_clamp;
          end
        end
        ST_DIVIDE: begin
          cnt <= cnt + 1'b1;
        end
        ST_GROW: begin
          window <= grow_sum[WIN_W] ? WIN_MAX : grow_sum[WIN_W-1:0];
        end
        default: begin
          cnt <= cnt;
        end
      endcase

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_fire) begin
        m_tvalid <= 1'b0;
      end

      // User must write configuration only while idle; the block does not enforce it.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DELAY_THRESHOLD) begin
          threshold <= cfg_data;
        end else if (cfg_index == REG_INITIAL_WINDOW) begin
          window <= {init_whole, {FRACTION_BITS{1'b0}}};
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_fire) begin
      mode      <= s_tuser[0];
      timed_out <= s_tuser[1];
      send_sr   <= s_tdata[TIME_W-1:0];
      ack_sr    <= s_tdata[2*TIME_W-1:TIME_W];
      thr_sr    <= {{(TIME_W-CFG_DATA_W){1'b0}}, threshold};
      rtt_sr    <= '0;                     // send events report zero RTT
    end else if (state == ST_RTT) begin
      // Advance one digit: operands shift down, RTT fills from the top
      send_sr <= send_sr >> DIGIT_W;
      ack_sr  <= ack_sr >> DIGIT_W;
      thr_sr  <= thr_sr >> DIGIT_W;
      rtt_sr  <= {rtt_digit, rtt_sr[TIME_W-1:DIGIT_W]};
    end

    if (state == ST_ADJUST) begin
      rem <= '0;
      quo <= FOUR_FX;
    end else if (state == ST_DIVIDE) begin
      rem <= div_ge ? div_trial[WHOLE_BITS-1:0] : div_shifted[WHOLE_BITS-1:0];
      quo <= {quo[DIV_STEPS-2:0], div_ge};
    end

    if (out_load) begin
      out_window <= window;
      out_rtt    <= rtt_sr;
    end
  end

  assign m_tdata = OUT_W'({out_rtt, out_window, out_window[WIN_W-1:FRACTION_BITS]});

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for delay_based_congestion_window_top: random and directed send/ack
// events, random stalls on both streams, and an in-bench window predictor.
// Depends on dbcw_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
  import dbcw_pkg::*;

  localparam int FRACTION_BITS = 8;
  localparam int WHOLE_BITS    = 16;
  localparam int WIN_W         = WHOLE_BITS + FRACTION_BITS;
  localparam int M_W           = ((WHOLE_BITS + WIN_W + TIME_W + 7) / 8) * 8;
  localparam logic [31:0] ONE_FX  = 32'd1 << FRACTION_BITS;
  localparam logic [31:0] HALF_FX = 32'd1 << (FRACTION_BITS - 1);
  localparam logic [31:0] WIN_MAX = (32'd1 << WIN_W) - 1;
  // Leave room for the slowest request before touching the registers.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 86;
  localparam int NUM_PHASES    = 5;

  typedef struct packed {
    logic              mode;
    logic              timeout;
    logic [TIME_W-1:0] send_ms;
    logic [TIME_W-1:0] ack_ms;
  } window_event_t;

  typedef struct packed {
    logic [WHOLE_BITS-1:0] whole;
    logic [WIN_W-1:0]      fixed;
    logic [TIME_W-1:0]     rtt;
  } window_report_t;

  // DUT ports; every input starts at a known value.
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [1:0]             s_tuser;
  logic [2*TIME_W-1:0]    s_tdata;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_W-1:0]         m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Request currently on the input stream
  window_event_t s_event = '0;

  // Predictor state, mirrors the block after reset
  logic [WIN_W-1:0]      win_model    = WIN_W'(1) << FRACTION_BITS;
  logic [CFG_DATA_W-1:0] thresh_model = THRESHOLD_RESET;

  window_event_t  event_q[$];
  window_report_t window_expect_q[$];
  window_report_t want_rpt;

  logic req_taken  = 1'b0;
  logic steady     = 1'b0;   // no idling on either side while set
  int   send_gap   = 0;
  int   ready_gap  = 0;
  int   errors     = 0;
  int   n_reports  = 0;
  int   n_acks     = 0;
  int   n_timeouts = 0;
  int   n_settings = 1;
  int   cycle_count = 0;

  assign s_tuser = {s_event.timeout, s_event.mode};
  assign s_tdata = {s_event.ack_ms, s_event.send_ms};

  delay_based_congestion_window_top #(
    .FRACTION_BITS(FRACTION_BITS),
    .WHOLE_BITS   (WHOLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Window load on a register write: zero counts as one datagram.
  function automatic logic [WIN_W-1:0] load_window(logic [CFG_DATA_W-1:0] whole);
    logic [CFG_DATA_W-1:0] w;
    w = (whole == '0) ? CFG_DATA_W'(1) : whole;
    return WIN_W'(w) << FRACTION_BITS;
  endfunction

  // Advance the predicted window by one event and return the report it yields.
  function automatic window_report_t apply_event(window_event_t ev);
    window_report_t        rpt;
    logic [TIME_W-1:0]     rtt;
    logic [31:0]           w;
    logic [31:0]           inc;
    logic [WHOLE_BITS-1:0] whole;
    w   = 32'(win_model);
    rtt = '0;
    if (ev.mode == MODE_SEND) begin
      // Timeout halves, but never at or below 2.0
      if (ev.timeout && w > (32'd2 << FRACTION_BITS)) w = w >> 1;
    end else begin
      rtt = ev.ack_ms - ev.send_ms;
      if (rtt > TIME_W'(thresh_model)) w = (w >= HALF_FX) ? w - HALF_FX : 32'd0;
      if (w < ONE_FX) w = ONE_FX;
      // Equal RTT neither grows nor shrinks
      if (rtt < TIME_W'(thresh_model)) begin
        whole = WHOLE_BITS'(w >> FRACTION_BITS);
        inc   = (32'd4 << FRACTION_BITS) / 32'(whole);
        w     = (inc > WIN_MAX - w) ? WIN_MAX : w + inc;
      end
    end
    win_model = w[WIN_W-1:0];
    rpt.whole = WHOLE_BITS'(win_model >> FRACTION_BITS);
    rpt.fixed = win_model;
    rpt.rtt   = rtt;
    return rpt;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_event(logic mode, logic timeout,
                                    logic [TIME_W-1:0] send_ms, logic [TIME_W-1:0] ack_ms);
    window_event_t ev;
    ev.mode    = mode;
    ev.timeout = timeout;
    ev.send_ms = send_ms;
    ev.ack_ms  = ack_ms;
    event_q.push_back(ev);
  endfunction

  // Random event shaped around the threshold: mostly acks that grow the window,
  // some that shrink it, exact hits, wrapped times and timed-out sends.
  function automatic window_event_t make_event(logic [CFG_DATA_W-1:0] th);
    window_event_t     ev;
    logic [TIME_W-1:0] rtt;
    int                r;
    ev.send_ms = {$urandom, $urandom};
    ev.timeout = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 25) begin
      ev.mode    = MODE_SEND;
      ev.timeout = ($urandom_range(0, 2) == 0);
      ev.ack_ms  = {$urandom, $urandom};
    end else begin
      ev.mode = MODE_ACK;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: rtt = TIME_W'($urandom_range(0, 32'(th)));
        5, 6:          rtt = TIME_W'(th) + 1 + TIME_W'($urandom_range(0, 500));
        7:             rtt = TIME_W'(th) - 2 + TIME_W'($urandom_range(0, 4));
        8:             rtt = {$urandom, $urandom};
        default:       rtt = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      ev.ack_ms = ev.send_ms + rtt;
    end
    return ev;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Block until every request is taken and answered, then let the pipe drain.
  task automatic wait_idle();
    do @(posedge clk);
    while (event_q.size() != 0 || s_tvalid || window_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: present the next queued event once the current one is taken
  // and the random gap has run out.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (send_gap != 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (event_q.size() != 0) begin
        s_event  <= event_q.pop_front();
        s_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure: stall at random, otherwise stay ready.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_gap != 0) begin
      m_tready  <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_gap <= pick_gap();
    end
  end

  // Monitor: check results against the oldest prediction, predict taken
  // requests, track register writes.
  always @(posedge clk) begin
    req_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_reports++;
        if (window_expect_q.size() == 0) begin
          $display("%0t ns: result with no request outstanding, got 0x%0h",
                   $time, m_tdata);
          errors++;
        end else begin
          want_rpt = window_expect_q.pop_front();
          check_field("window_whole", 64'(want_rpt.whole), 64'(m_tdata[WHOLE_BITS-1:0]));
          check_field("window_fixed", 64'(want_rpt.fixed),
                      64'(m_tdata[WHOLE_BITS +: WIN_W]));
          check_field("rtt_ms", want_rpt.rtt, m_tdata[WHOLE_BITS + WIN_W +: TIME_W]);
        end
      end
      if (s_tvalid && s_tready) begin
        window_expect_q.push_back(apply_event(s_event));
        if (s_event.mode == MODE_ACK) n_acks++;
        else if (s_event.timeout) n_timeouts++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELAY_THRESHOLD: thresh_model = cfg_data;
          REG_INITIAL_WINDOW:  win_model    = load_window(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d results still expected",
               $time, cycle_count, window_expect_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] th;
    logic [CFG_DATA_W-1:0] iw;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Defaults: threshold 80, window 1.0
    add_event(MODE_SEND, 1'b0, '0, '0);                // plain send
    add_event(MODE_SEND, 1'b1, '1, '1);                // timeout at 1.0 holds
    add_event(MODE_ACK,  1'b0, '0, '0);                // RTT 0 grows by 4.0
    add_event(MODE_ACK,  1'b1, 64'd100, 64'd110);      // timeout flag ignored on ack
    add_event(MODE_ACK,  1'b0, 64'd1000, 64'd1080);    // RTT equal to threshold
    add_event(MODE_ACK,  1'b0, 64'd1000, 64'd1081);    // just above: drop 0.5
    add_event(MODE_ACK,  1'b0, 64'd1, 64'd0);          // wrapped RTT, all ones
    add_event(MODE_ACK,  1'b0, '1, '1);                // all-ones stamps, RTT 0
    add_event(MODE_ACK,  1'b0, {32{2'b01}}, {32{2'b01}} + 64'd79);
    repeat (4) add_event(MODE_SEND, 1'b1, {32{2'b10}}, {32{2'b01}});  // halve until at or below 2.0
    repeat (4) add_event(MODE_ACK, 1'b0, 64'd0, {32{2'b10}});         // shrink to the clamp
    wait_idle();

    // Threshold zero, window written as zero
    write_reg(REG_DELAY_THRESHOLD, '0);
    write_reg(REG_INITIAL_WINDOW, '0);
    n_settings++;
    add_event(MODE_ACK,  1'b0, 64'd5, 64'd5);          // equal: clamp only
    add_event(MODE_ACK,  1'b0, 64'd5, 64'd6);          // shrink below 1.0, clamp
    add_event(MODE_SEND, 1'b1, '0, '1);
    wait_idle();

    // Largest threshold and window
    write_reg(REG_DELAY_THRESHOLD, '1);
    write_reg(REG_INITIAL_WINDOW, '1);
    n_settings++;
    add_event(MODE_ACK,  1'b0, '0, '0);                // growth at full window
    add_event(MODE_ACK,  1'b0, '0, 64'd65535);         // equal
    add_event(MODE_ACK,  1'b0, '0, 64'd65536);         // above
    add_event(MODE_SEND, 1'b1, '0, '0);                // halve
    wait_idle();

    // Random phases, each with its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin th = CFG_DATA_W'($urandom); iw = CFG_DATA_W'($urandom_range(1, 8)); end
        1:       begin th = THRESHOLD_RESET;       iw = 16'd2; end
        2:       begin th = '0;                    iw = CFG_DATA_W'($urandom); end
        3:       begin th = '1;                    iw = '1; end
        default: begin th = CFG_DATA_W'($urandom_range(0, 300));
                       iw = CFG_DATA_W'($urandom_range(0, 3)); end
      endcase
      write_reg(REG_DELAY_THRESHOLD, th);
      write_reg(REG_INITIAL_WINDOW, iw);
      n_settings++;
      steady = (p % 2 == 1);
      repeat (PHASE_ITEMS) event_q.push_back(make_event(th));
      wait_idle();
    end

    $display("Checked %0d window reports: %0d acks, %0d timed-out sends, the rest plain sends,",
             n_reports, n_acks, n_timeouts);
    $display("across %0d register settings with random stalls on both streams.", n_settings);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
